[src/mcss_pkg.sv]
package mcss_pkg;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [0:0] REG_TICKS_PER_STEP = 1'b0;

   localparam logic [7:0] TICKS_PER_STEP_RESET = 8'd10;
   localparam logic [6:0] COUNT_MAX = 7'd99;
   localparam logic [6:0] SCALE_NUM = 7'd99;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_MODE   = 2'd1,
      OP_CHANGE = 2'd2,
      OP_SAMPLE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_AUTO   = 2'd0,
      MODE_UP     = 2'd1,
      MODE_DOWN   = 2'd2,
      MODE_SAMPLE = 2'd3
   } mode_type;

   // segments a..g, a in bit 6
   function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
      logic [6:0] pattern;
      unique case (digit)
         4'd0:    pattern = 7'h7E;
         4'd1:    pattern = 7'h30;
         4'd2:    pattern = 7'h6D;
         4'd3:    pattern = 7'h79;
         4'd4:    pattern = 7'h33;
         4'd5:    pattern = 7'h5B;
         4'd6:    pattern = 7'h5F;
         4'd7:    pattern = 7'h70;
         4'd8:    pattern = 7'h7F;
         4'd9:    pattern = 7'h7B;
         default: pattern = 7'h7E;
      endcase
      return pattern;
   endfunction

endpackage

[src/mode_counter_seven_segment.sv]
// Two-digit mode counter with seven-segment output. Each request carries an
// event kind on req_tuser (tick, mode press, change press, sample) and a
// converter sample on req_tdata; every request yields exactly one response
// with the displayed value, the segment patterns of its two digits and the
// mode after the event. One request is taken per clock cycle, but
// back-pressure on the response side stalls both stages and then the
// request side (state update and scaling in the first register stage,
// digit split and segment decode in the second). ticks_per_step sits
// at byte address 0 of the CSR port and resets to 10.
module mode_counter_seven_segment
   import mcss_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] sample
   input  logic [1:0]                req_tuser,   // [1:0] opcode
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [6:0] ones_segments, [13:7] tens_segments, [20:14] shown_value, [23:21] zero
   output logic [23:0]               rsp_tdata,
   output logic [1:0]                rsp_tuser,   // [1:0] current_mode
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic [7:0]  ticks_per_step_ff;
   logic [1:0]  mode_ff, mode_in;
   logic [6:0]  count_ff, count_in;
   logic [7:0]  tick_count_ff, tick_count_in;
   logic [7:0]  last_sample_ff, last_sample_in;

   logic        s1_valid_ff, s1_valid_in;
   logic [6:0]  s1_shown_ff, s1_shown_in;
   logic [1:0]  s1_mode_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  rsp_ones_ff, rsp_ones_in;
   logic [6:0]  rsp_tens_ff, rsp_tens_in;
   logic [6:0]  rsp_shown_ff;
   logic [1:0]  rsp_mode_ff;

   logic        out_free;
   logic        s1_adv;
   logic        accept;
   logic        csr_write;
   logic [7:0]  tick_inc;
   logic [14:0] scaled_prod;
   logic [15:0] scaled_quot;
   logic [3:0]  tens_digit;
   logic [6:0]  ones_value;
   opcode_type  opcode;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_TICKS_PER_STEP) ?
                       {{(CSR_DATA_WIDTH-8){1'b0}}, ticks_per_step_ff} : '0;

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign s1_adv     = s1_valid_ff & out_free;
   assign req_tready = ~s1_valid_ff | out_free;
   assign accept     = req_tvalid & req_tready;
   assign opcode     = opcode_type'(req_tuser);
   assign tick_inc   = tick_count_ff + 8'd1;

   assign s1_valid_in  = accept | (s1_valid_ff & ~out_free);
   assign rsp_valid_in = s1_adv | (rsp_valid_ff & ~rsp_tready);

   always_comb begin
      mode_in        = mode_ff;
      count_in       = count_ff;
      tick_count_in  = tick_count_ff;
      last_sample_in = last_sample_ff;
      if (accept) begin
         unique case (opcode)
            OP_TICK: begin
               if (mode_ff == MODE_AUTO) begin
                  if (tick_inc >= ticks_per_step_ff) begin
                     tick_count_in = 8'd0;
                     count_in      = (count_ff >= COUNT_MAX) ? 7'd0 : count_ff + 7'd1;
                  end else begin
                     tick_count_in = tick_inc;
                  end
               end
            end
            OP_MODE: begin
               mode_in = mode_ff + 2'd1;
            end
            OP_CHANGE: begin
               if (mode_ff == MODE_UP) begin
                  if (count_ff < COUNT_MAX) count_in = count_ff + 7'd1;
               end else if (mode_ff == MODE_DOWN) begin
                  if (count_ff > 7'd0) count_in = count_ff - 7'd1;
               end
            end
            OP_SAMPLE: begin
               last_sample_in = req_tdata;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   // floor(p / 255) = (p + (p >> 8) + 1) >> 8 for p below 65535
   always_comb begin
      scaled_prod = {7'd0, last_sample_in} * {8'd0, SCALE_NUM};
      scaled_quot = ({1'b0, scaled_prod} + {9'd0, scaled_prod[14:8]} + 16'd1) >> 8;
      s1_shown_in = (mode_in == MODE_SAMPLE) ? scaled_quot[6:0] : count_in;
   end

   always_comb begin
      tens_digit = 4'd0;
      for (int i = 1; i <= 9; i++) begin
         if (s1_shown_ff >= 7'(i * 10)) tens_digit = 4'(i);
      end
      ones_value  = s1_shown_ff - ({3'd0, tens_digit} << 3) - ({3'd0, tens_digit} << 1);
      rsp_ones_in = seg_pattern(ones_value[3:0]);
      rsp_tens_in = seg_pattern(tens_digit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_step_ff <= TICKS_PER_STEP_RESET;
         mode_ff           <= MODE_AUTO;
         count_ff          <= 7'd0;
         tick_count_ff     <= 8'd0;
         last_sample_ff    <= 8'd0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write && csr_pready && csr_paddr[2] == REG_TICKS_PER_STEP) begin
            ticks_per_step_ff <= csr_pwdata[7:0];
         end
         mode_ff        <= mode_in;
         count_ff       <= count_in;
         tick_count_ff  <= tick_count_in;
         last_sample_ff <= last_sample_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_shown_ff <= s1_shown_in;
         s1_mode_ff  <= mode_in;
      end
      if (s1_adv) begin
         rsp_ones_ff  <= rsp_ones_in;
         rsp_tens_ff  <= rsp_tens_in;
         rsp_shown_ff <= s1_shown_ff;
         rsp_mode_ff  <= s1_mode_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_shown_ff, rsp_tens_ff, rsp_ones_ff};
   assign rsp_tuser  = rsp_mode_ff;

   a_shown_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_shown_ff <= COUNT_MAX)
      else $error("shown value above 99");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      out_free |-> req_tready)
      else $error("request stalled with free response register");

   a_mode_step: assert property (@(posedge clock) disable iff (reset)
      (accept && opcode == OP_MODE) |=> mode_ff == 2'($past(mode_ff) + 2'd1))
      else $error("mode press did not advance mode");

   a_no_lost_request: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff)
      else $error("stalled request dropped");

endmodule

[sim/mcss_display_checker.sv]
`timescale 1ns / 100ps

module mcss_display_checker
   import mcss_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] sample
   input  logic [1:0]                req_tuser,   // [1:0] opcode
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [6:0] ones_segments, [13:7] tens_segments, [20:14] shown_value, [23:21] zero
   input  logic [23:0]               rsp_tdata,
   input  logic [1:0]                rsp_tuser,   // [1:0] current_mode
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic                      csr_pready,
   output int                        mismatch_count,
   output int                        displays_pending
);

   typedef struct packed {
      logic [6:0] ones_segments;
      logic [6:0] tens_segments;
      logic [6:0] shown_value;
      mode_type   current_mode;
   } display_type;

   // digit 0 in the lowest seven bits
   localparam logic [69:0] DIGIT_SEGMENTS = {
      7'h7B, 7'h7F, 7'h70, 7'h5F, 7'h5B, 7'h33, 7'h79, 7'h6D, 7'h30, 7'h7E
   };

   logic [7:0]  ticks_per_step;
   logic [7:0]  tick_count;
   logic [7:0]  last_sample;
   logic [6:0]  count;
   mode_type    mode;
   display_type expected_displays[$];

   function automatic display_type advance_display(input opcode_type op,
                                                   input logic [7:0] smp);
      int          shown;
      display_type d;
      case (op)
         OP_TICK: begin
            if (mode == MODE_AUTO) begin
               tick_count = tick_count + 8'd1;
               if (tick_count >= ticks_per_step) begin
                  tick_count = 8'd0;
                  count = (count >= COUNT_MAX) ? 7'd0 : count + 7'd1;
               end
            end
         end
         OP_MODE: begin
            mode = mode_type'(mode + 2'd1);
         end
         OP_CHANGE: begin
            if (mode == MODE_UP && count < COUNT_MAX)
               count = count + 7'd1;
            else if (mode == MODE_DOWN && count > 7'd0)
               count = count - 7'd1;
         end
         default: begin
            last_sample = smp;
         end
      endcase
      if (mode == MODE_SAMPLE)
         shown = (int'(last_sample) * int'(SCALE_NUM)) / 255;
      else
         shown = int'(count);
      d.ones_segments = DIGIT_SEGMENTS[(shown % 10) * 7 +: 7];
      d.tens_segments = DIGIT_SEGMENTS[(shown / 10) * 7 +: 7];
      d.shown_value = shown[6:0];
      d.current_mode = mode;
      return d;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: display mismatch: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      display_type want;
      if (reset) begin
         ticks_per_step = TICKS_PER_STEP_RESET;
         tick_count = 8'd0;
         last_sample = 8'd0;
         count = 7'd0;
         mode = MODE_AUTO;
         mismatch_count = 0;
         expected_displays.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[CSR_ADDR_WIDTH-1:2] == REG_TICKS_PER_STEP)
            ticks_per_step = csr_pwdata[7:0];
         // response side first: a display never leaves in its request's cycle
         if (rsp_tvalid && rsp_tready) begin
            if (expected_displays.size() == 0) begin
               flag_mismatch($sformatf("unexpected response tdata %h tuser %0d",
                                       rsp_tdata, rsp_tuser));
            end else begin
               want = expected_displays.pop_front();
               if (rsp_tdata[6:0] !== want.ones_segments
                   || rsp_tdata[13:7] !== want.tens_segments
                   || rsp_tdata[20:14] !== want.shown_value
                   || rsp_tdata[23:21] !== 3'b000
                   || rsp_tuser !== want.current_mode)
                  flag_mismatch($sformatf(
                     {"expected ones %h tens %h value %0d mode %0d, ",
                      "got ones %h tens %h value %0d mode %0d pad %b"},
                     want.ones_segments, want.tens_segments, want.shown_value,
                     want.current_mode, rsp_tdata[6:0], rsp_tdata[13:7],
                     rsp_tdata[20:14], rsp_tuser, rsp_tdata[23:21]));
            end
         end
         if (req_tvalid && req_tready)
            expected_displays.push_back(advance_display(opcode_type'(req_tuser), req_tdata));
      end
      displays_pending = expected_displays.size();
   end

endmodule

[sim/mode_counter_seven_segment_test.sv]
`timescale 1ns / 100ps

module mode_counter_seven_segment_test;
   import mcss_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [7:0]                req_tdata;
   logic [1:0]                req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [23:0]               rsp_tdata;
   logic [1:0]                rsp_tuser;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;
   int                        mismatch_count;
   int                        displays_pending;
   bit                        steady;   // no idling on either side

   mode_counter_seven_segment dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mcss_display_checker display_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .mismatch_count   (mismatch_count),
      .displays_pending (displays_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("mode_counter_seven_segment_test failed");
      $finish;
   end

   task automatic send_event(input opcode_type op, input logic [7:0] smp);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= smp;
      do @(posedge clock); while (!req_tready);
   endtask

   // idle between phases until every display is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (displays_pending == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_ticks_per_step(input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_TICKS_PER_STEP, 2'b00};
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // runs of ticks and change presses split by mode presses and samples, with some random events
   task automatic run_events(input int items);
      int         sent;
      int         run;
      int         kind;
      int         k;
      opcode_type op;
      sent = 0;
      while (sent < items) begin
         kind = $urandom_range(0, 9);
         if (kind < 3) begin
            op = OP_TICK;
            run = $urandom_range(1, 40);
         end else if (kind < 6) begin
            op = OP_CHANGE;
            run = $urandom_range(1, 60);
         end else if (kind < 8) begin
            op = OP_MODE;
            run = $urandom_range(1, 4);
         end else if (kind == 8) begin
            op = OP_SAMPLE;
            run = $urandom_range(1, 3);
         end else begin
            op = opcode_type'($urandom_range(0, 3));
            run = 1;
         end
         for (k = 0; k < run && sent < items; k++) begin
            send_event(op, 8'($urandom_range(0, 255)));
            sent++;
         end
      end
   endtask

   initial begin
      int unsigned phase_steps[7];
      int          p;
      phase_steps = '{255, 1, 10, 0, 0, 200, 1};
      phase_steps[4] = $urandom_range(2, 254);
      steady = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 8'd0;
      req_tuser <= OP_TICK;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero ticks per step: every tick steps
      write_ticks_per_step(8'd0);
      send_event(OP_TICK, 8'h00);
      send_event(OP_CHANGE, 8'hFF);
      send_event(OP_SAMPLE, 8'hFF);
      send_event(OP_MODE, 8'h00);
      send_event(OP_CHANGE, 8'h55);
      send_event(OP_TICK, 8'hAA);
      send_event(OP_MODE, 8'h00);
      send_event(OP_CHANGE, 8'h00);
      send_event(OP_CHANGE, 8'h00);
      send_event(OP_CHANGE, 8'h00);
      send_event(OP_MODE, 8'h00);
      send_event(OP_SAMPLE, 8'h00);
      send_event(OP_SAMPLE, 8'hAA);
      send_event(OP_CHANGE, 8'h00);
      send_event(OP_TICK, 8'h00);
      send_event(OP_SAMPLE, 8'h80);
      send_event(OP_MODE, 8'h00);
      send_event(OP_TICK, 8'h01);
      send_event(OP_TICK, 8'hFE);
      drain();

      // one after 255 drops the limit below a part-filled tick count
      for (p = 0; p < 7; p++) begin
         write_ticks_per_step(8'(phase_steps[p]));
         steady = (p == 2 || p == 5);
         run_events(270);
         drain();
      end

      if (mismatch_count == 0) begin
         $display("mode_counter_seven_segment_test passed");
      end else begin
         $display("mode_counter_seven_segment_test failed");
      end
      $finish;
   end

   // response side; one long hold-off lets the pipeline fill and stall requests
   initial begin
      int gap;
      int taken;
      taken = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (taken == 150)
            gap = 80;
         else
            gap = steady ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

endmodule
